[rtl/core/swpp_pkg.sv]
// Package for the sliding window peak picker: beat types, field widths,
// register indexes and parameter defaults. No dependencies.
`default_nettype none

package swpp_pkg;

  localparam int DATA_WIDTH         = 16;
  localparam int LOC_W              = 16;
  localparam int CNT_OUT_W          = 9;
  localparam int LEN_REG_W          = 16;
  localparam int WIN_REG_W          = 7;
  localparam int CFG_DATA_W         = 16;
  localparam int CFG_IDX_W          = 1;

  localparam int MAX_WINDOW_DEFAULT = 64;
  localparam int PEAK_LIMIT_DEFAULT = 256;

  localparam logic [CFG_IDX_W-1:0] REG_SIGNAL_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 1'b1;

  localparam logic KIND_PEAK  = 1'b0;
  localparam logic KIND_COUNT = 1'b1;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] sample;
    logic signed [DATA_WIDTH-1:0] threshold_value;
  } in_beat_t;

  typedef struct packed {
    logic                 kind;
    logic [LOC_W-1:0]     location;
    logic [CNT_OUT_W-1:0] peak_count;
    logic                 frame_last;
  } out_beat_t;

endpackage

`default_nettype wire

[rtl/core/sliding_window_peak_picker.sv]
// Sliding window peak picker top level: window shift line, peak check stage
// and 8-entry result queue. Depends on swpp_pkg.
// Results of an accepted beat are registered in the window shift line, then
// checked and written into the result queue, which drives out_. Throughput: one
// input beat per cycle; the queue stalls the input only when it runs near full.
// Synchronous active-low reset clears window, counters, queue pointers and registers.
`default_nettype none

module sliding_window_peak_picker
  import swpp_pkg::*;
#(
  parameter int MAX_WINDOW = MAX_WINDOW_DEFAULT,
  parameter int PEAK_LIMIT = PEAK_LIMIT_DEFAULT
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output      logic                  in_stall,
  input  wire in_beat_t              in_data,
  output      logic                  out_valid,
  input  wire logic                  out_stall,
  output      out_beat_t             out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int WW    = ($clog2(MAX_WINDOW + 1) > WIN_REG_W) ?
                         $clog2(MAX_WINDOW + 1) : WIN_REG_W;
  localparam int IW    = $clog2(MAX_WINDOW);
  localparam int CW    = $clog2(PEAK_LIMIT + 1);
  localparam int DEPTH = 8;
  localparam int PW    = $clog2(DEPTH);
  localparam int QW    = $clog2(DEPTH + 1);

  logic [LEN_REG_W-1:0] signal_length_r;
  logic [WIN_REG_W-1:0] window_length_r;

  logic signed [DATA_WIDTH-1:0] samp_win_r [MAX_WINDOW];
  logic signed [DATA_WIDTH-1:0] thr_win_r  [MAX_WINDOW];

  logic [LOC_W-1:0] pos_r, pos_nxt, p_in;
  logic [LOC_W-1:0] p_r;
  logic             end_in, end_r, v1_r;
  logic [CW-1:0]    peaks_r, peaks_nxt;

  logic [WW-1:0]        w_eff, w_half, mid_w;
  logic [LEN_REG_W-1:0] len_eff;
  logic [IW-1:0]        mid_idx;
  logic signed [DATA_WIDTH-1:0] mid_val, mid_thr;
  logic                 is_max, push_peak, push_cnt;
  logic [LOC_W-1:0]     loc;
  logic [CW-1:0]        peaks_inc;

  out_beat_t        fifo_r [DEPTH];
  out_beat_t        peak_beat, cnt_beat;
  logic [PW-1:0]    wp_r, rp_r;
  logic [QW-1:0]    fcnt_r;
  logic [QW:0]      room_need;
  logic [1:0]       n_push;
  logic             in_acc, out_acc;

  always_comb begin
    w_eff = WW'(window_length_r);
    if (w_eff == '0) begin
      w_eff = WW'(1);
    end else if (w_eff > WW'(MAX_WINDOW)) begin
      w_eff = WW'(MAX_WINDOW);
    end
    len_eff = (signal_length_r == '0) ? LEN_REG_W'(1) : signal_length_r;
    w_half  = w_eff >> 1;
    mid_w   = w_eff - WW'(1) - w_half;
    mid_idx = mid_w[IW-1:0];
  end

  // Input side: accept, advance position, decide frame end.
  assign room_need = (QW + 1)'(fcnt_r) + (v1_r ? (QW + 1)'(2) : '0);
  assign in_stall  = room_need > (QW + 1)'(DEPTH - 2);
  assign in_acc    = in_valid && !in_stall;
  assign p_in      = pos_r + LOC_W'(1);
  assign end_in    = p_in >= len_eff;
  assign pos_nxt   = end_in ? '0 : p_in;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      signal_length_r <= LEN_REG_W'(1);
      window_length_r <= WIN_REG_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SIGNAL_LENGTH: signal_length_r <= cfg_wdata[LEN_REG_W-1:0];
        REG_WINDOW_LENGTH: window_length_r <= cfg_wdata[WIN_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < MAX_WINDOW; k++) begin
        samp_win_r[k] <= '0;
        thr_win_r[k]  <= '0;
      end
      pos_r <= '0;
      v1_r  <= 1'b0;
      end_r <= 1'b0;
      p_r   <= '0;
    end else begin
      v1_r <= in_acc;
      if (in_acc) begin
        for (int k = 1; k < MAX_WINDOW; k++) begin
          samp_win_r[k] <= samp_win_r[k-1];
          thr_win_r[k]  <= thr_win_r[k-1];
        end
        samp_win_r[0] <= in_data.sample;
        thr_win_r[0]  <= in_data.threshold_value;
        pos_r <= pos_nxt;
        p_r   <= p_in;
        end_r <= end_in;
      end
    end
  end

  // Check stage: window held after the shift of the beat in flight.
  always_comb begin
    mid_val = samp_win_r[mid_idx];
    mid_thr = thr_win_r[mid_idx];
    is_max  = 1'b1;
    for (int k = 0; k < MAX_WINDOW; k++) begin
      if (WW'(k) < w_eff && WW'(k) != mid_w && samp_win_r[k] > mid_val) begin
        is_max = 1'b0;
      end
    end
    push_peak = v1_r && (p_r >= LOC_W'(w_eff)) && is_max && (mid_val > mid_thr) &&
                (peaks_r < CW'(PEAK_LIMIT));
    push_cnt  = v1_r && end_r;
    peaks_inc = push_peak ? peaks_r + CW'(1) : peaks_r;
    peaks_nxt = push_cnt ? '0 : peaks_inc;
    loc       = p_r - LOC_W'(w_eff) + LOC_W'(w_half) + LOC_W'(1);

    peak_beat.kind       = KIND_PEAK;
    peak_beat.location   = loc;
    peak_beat.peak_count = CNT_OUT_W'(peaks_inc);
    peak_beat.frame_last = 1'b0;

    cnt_beat.kind        = KIND_COUNT;
    cnt_beat.location    = '0;
    cnt_beat.peak_count  = CNT_OUT_W'(peaks_inc);
    cnt_beat.frame_last  = 1'b1;

    n_push = {1'b0, push_peak} + {1'b0, push_cnt};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peaks_r <= '0;
    end else if (v1_r) begin
      peaks_r <= peaks_nxt;
    end
  end

  // Result queue: up to two pushes and one pop per cycle.
  assign out_valid = fcnt_r != '0;
  assign out_data  = fifo_r[rp_r];
  assign out_acc   = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (push_peak) begin
      fifo_r[wp_r] <= peak_beat;
      if (push_cnt) begin
        fifo_r[wp_r + PW'(1)] <= cnt_beat;
      end
    end else if (push_cnt) begin
      fifo_r[wp_r] <= cnt_beat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      rp_r   <= '0;
      fcnt_r <= '0;
    end else begin
      wp_r   <= wp_r + PW'(n_push);
      if (out_acc) begin
        rp_r <= rp_r + PW'(1);
      end
      fcnt_r <= fcnt_r + QW'(n_push) - QW'(out_acc);
    end
  end

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fcnt_r <= QW'(DEPTH))
    else $error("result queue overflow");

  a_frame_rearm: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && end_r) |=> (peaks_r == '0))
    else $error("peak count not cleared at frame end");

  a_peak_limit: assert property (@(posedge clk) disable iff (!rst_n)
    peaks_r <= CW'(PEAK_LIMIT))
    else $error("peak count beyond limit");

endmodule

`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 100ps
// Testbench for sliding_window_peak_picker: directed and random frames, random idling on
// both channels, every result checked against an in-bench window predictor.
// Depends on swpp_pkg and the block's RTL.

module testbench;
  import swpp_pkg::*;

  localparam int WIN_DEPTH      = MAX_WINDOW_DEFAULT;
  localparam int PEAK_CAP       = PEAK_LIMIT_DEFAULT;
  localparam int IDLE_MAX       = 6;
  localparam int SETTLE_CYCLES  = 4;
  localparam int WATCHDOG_LIMIT = 2000;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_beat_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_beat_t             out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  logic signed [DATA_WIDTH-1:0] sample_hist [WIN_DEPTH];
  logic signed [DATA_WIDTH-1:0] thresh_hist [WIN_DEPTH];
  logic [LOC_W-1:0]             frame_pos;
  int unsigned                  peaks_in_frame;
  logic [LEN_REG_W-1:0]         frame_len_reg;
  logic [WIN_REG_W-1:0]         win_len_reg;
  out_beat_t                    expected_reports [$];

  bit idle_on;
  int out_hold;
  int n_errors;
  int quiet_cycles;
  int unsigned items_sent;

  sliding_window_peak_picker u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #10 clk = ~clk;

  function automatic void pick_peaks(input in_beat_t beat);
    int unsigned w;
    int unsigned len;
    int unsigned pos;
    int unsigned mid;
    int unsigned loc;
    int k;
    logic signed [DATA_WIDTH-1:0] center;
    bit is_max;
    out_beat_t rep;
    w = win_len_reg;
    if (w < 1) w = 1;
    if (w > WIN_DEPTH) w = WIN_DEPTH;
    len = frame_len_reg;
    if (len < 1) len = 1;
    for (k = WIN_DEPTH - 1; k > 0; k--) begin
      sample_hist[k] = sample_hist[k-1];
      thresh_hist[k] = thresh_hist[k-1];
    end
    sample_hist[0] = beat.sample;
    thresh_hist[0] = beat.threshold_value;
    frame_pos = frame_pos + 1'b1;
    pos = frame_pos;
    if (pos >= w) begin
      mid = w - 1 - w / 2;
      center = sample_hist[mid];
      is_max = 1'b1;
      for (k = 0; k < w; k++) begin
        if (k != mid && sample_hist[k] > center) is_max = 1'b0;
      end
      if (is_max && center > thresh_hist[mid] && peaks_in_frame < PEAK_CAP) begin
        loc = pos - w + w / 2 + 1;
        peaks_in_frame++;
        rep.kind       = KIND_PEAK;
        rep.location   = loc[LOC_W-1:0];
        rep.peak_count = peaks_in_frame[CNT_OUT_W-1:0];
        rep.frame_last = 1'b0;
        expected_reports.push_back(rep);
      end
    end
    if (pos >= len) begin
      rep.kind       = KIND_COUNT;
      rep.location   = '0;
      rep.peak_count = peaks_in_frame[CNT_OUT_W-1:0];
      rep.frame_last = 1'b1;
      expected_reports.push_back(rep);
      frame_pos      = '0;
      peaks_in_frame = 0;
    end
  endfunction

  function automatic in_beat_t beat_of(input int s, input int t);
    in_beat_t b;
    b.sample          = DATA_WIDTH'(s);
    b.threshold_value = DATA_WIDTH'(t);
    return b;
  endfunction

  function automatic logic [DATA_WIDTH-1:0] extreme_value();
    case ($urandom_range(0, 3))
      0:       return 16'h8000;
      1:       return 16'hFFFF;
      2:       return 16'h0000;
      default: return 16'h7FFF;
    endcase
  endfunction

  // flavors: full range, near ties, extremes, low thresholds
  function automatic in_beat_t random_beat(input int unsigned flavor);
    in_beat_t b;
    b.sample          = DATA_WIDTH'($urandom_range(0, 65535));
    b.threshold_value = DATA_WIDTH'($urandom_range(0, 65535));
    case (flavor)
      1: begin
        b.sample          = DATA_WIDTH'($urandom_range(0, 4) - 2);
        b.threshold_value = DATA_WIDTH'($urandom_range(0, 4) - 4);
      end
      2: begin
        b.sample          = extreme_value();
        b.threshold_value = extreme_value();
      end
      3: b.threshold_value = 16'h8000;
      default: ;
    endcase
    return b;
  endfunction

  task automatic send_beat(input in_beat_t beat);
    int gap;
    gap = idle_on ? $urandom_range(0, IDLE_MAX) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (in_stall);
    pick_peaks(beat);
    items_sent++;
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_reports.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_SIGNAL_LENGTH) frame_len_reg = value[LEN_REG_W-1:0];
    else win_len_reg = value[WIN_REG_W-1:0];
  endtask

  task automatic test_single_sample_frames();
    send_beat(beat_of(32767, -32768));
    send_beat(beat_of(-32768, 32767));
    send_beat(beat_of(0, 0));
    send_beat(beat_of(-1, -2));
    // zero lengths act as one
    set_reg(REG_WINDOW_LENGTH, 0);
    set_reg(REG_SIGNAL_LENGTH, 0);
    send_beat(beat_of(1, 0));
    send_beat(beat_of(-5, -5));
  endtask

  task automatic test_ties_and_extremes();
    int s [8] = '{-32768, 32767, 32767, 32767, 0, 7, 7, -32768};
    int t [8] = '{32767, -32768, 32766, 32767, -32768, 6, 7, -32768};
    set_reg(REG_SIGNAL_LENGTH, 8);
    set_reg(REG_WINDOW_LENGTH, 3);
    foreach (s[i]) send_beat(beat_of(s[i], t[i]));
  endtask

  task automatic test_window_beyond_frame();
    set_reg(REG_WINDOW_LENGTH, 5);
    set_reg(REG_SIGNAL_LENGTH, 3);
    repeat (3) send_beat(random_beat(3));
    // saturates to the deepest window
    set_reg(REG_WINDOW_LENGTH, 127);
    set_reg(REG_SIGNAL_LENGTH, 2);
    repeat (2) send_beat(random_beat(0));
  endtask

  task automatic test_midframe_changes();
    set_reg(REG_SIGNAL_LENGTH, 10);
    set_reg(REG_WINDOW_LENGTH, 3);
    repeat (4) send_beat(random_beat(1));
    set_reg(REG_WINDOW_LENGTH, 1);
    repeat (2) send_beat(random_beat(3));
    set_reg(REG_SIGNAL_LENGTH, 16'hFFFF);
    send_beat(random_beat(0));
    // lower below the current position: next beat closes the frame
    set_reg(REG_SIGNAL_LENGTH, 3);
    send_beat(random_beat(3));
  endtask

  task automatic test_peak_limit();
    set_reg(REG_WINDOW_LENGTH, 1);
    set_reg(REG_SIGNAL_LENGTH, 300);
    repeat (300) send_beat(random_beat(3));
  endtask

  task automatic test_random_frames(input int unsigned n_items);
    int unsigned stop_at;
    int unsigned len;
    int unsigned win;
    int unsigned count;
    int unsigned flavor;
    int unsigned pick;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      idle_on = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 9))
        0:       len = $urandom_range(0, 2);
        1:       len = $urandom_range(60, 140);
        default: len = $urandom_range(1, 40);
      endcase
      case ($urandom_range(0, 9))
        0:       win = $urandom_range(0, 1);
        1:       win = $urandom_range(60, 127);
        2:       win = WIN_DEPTH;
        default: win = $urandom_range(2, 9);
      endcase
      pick = $urandom_range(0, 3);
      if (pick != 1) set_reg(REG_SIGNAL_LENGTH, CFG_DATA_W'(len));
      if (pick != 0) begin
        set_reg(REG_WINDOW_LENGTH,
                {(CFG_DATA_W - WIN_REG_W)'($urandom), WIN_REG_W'(win)});
      end
      flavor = $urandom_range(0, 3);
      count  = (len == 0 ? 1 : len) * $urandom_range(1, 3) + $urandom_range(0, 5);
      repeat (count) begin
        send_beat(random_beat($urandom_range(0, 7) == 0 ? $urandom_range(0, 3) : flavor));
      end
    end
  endtask

  always @(negedge clk) begin
    if (out_hold > 0) begin
      out_stall <= 1'b1;
      out_hold--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    out_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      out_hold = idle_on ? $urandom_range(0, IDLE_MAX) : 0;
      if (expected_reports.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual kind %0d loc %0d count %0d last %0d",
                 $time, out_data.kind, out_data.location, out_data.peak_count,
                 out_data.frame_last);
        n_errors++;
      end else begin
        want = expected_reports.pop_front();
        if (out_data !== want) begin
          $display("%0t: mismatch, expected kind %0d loc %0d count %0d last %0d,",
                   $time, want.kind, want.location, want.peak_count, want.frame_last);
          $display("%0t:   actual kind %0d loc %0d count %0d last %0d",
                   $time, out_data.kind, out_data.location, out_data.peak_count,
                   out_data.frame_last);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int k;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    out_stall    = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = REG_SIGNAL_LENGTH;
    cfg_wdata    = '0;
    out_hold     = 0;
    n_errors     = 0;
    quiet_cycles = 0;
    items_sent   = 0;
    idle_on      = 1'b1;
    for (k = 0; k < WIN_DEPTH; k++) begin
      sample_hist[k] = '0;
      thresh_hist[k] = '0;
    end
    frame_pos      = '0;
    peaks_in_frame = 0;
    frame_len_reg  = 1;
    win_len_reg    = 1;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    test_single_sample_frames();
    test_ties_and_extremes();
    test_window_beyond_frame();
    test_midframe_changes();
    test_peak_limit();
    test_random_frames(1600);

    drain_results();
    repeat (SETTLE_CYCLES * 2) @(posedge clk);
    if (n_errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
